[hdl/packed_track_cell_decoder_macros.svh]
// Assertion macros shared by the packed track cell decoder modules.
`ifndef PACKED_TRACK_CELL_DECODER_MACROS_SVH
`define PACKED_TRACK_CELL_DECODER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PTCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PTCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ptcd_pkg.sv]
// Types, codes and the period table of the packed track cell decoder.
package ptcd_pkg;

  // Parser and sequencer states.
  typedef enum logic [1:0] {
    ST_LEAD,
    ST_INFO,
    ST_PARAM,
    ST_SKIP
  } state_t;

  // Which cell the datapath loads into the output register.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_INFO,
    EMIT_PARAM,
    EMIT_EMPTY
  } emit_t;

  // Class of a lead byte.
  typedef enum logic [1:0] {
    LEAD_NOTE,
    LEAD_FX,
    LEAD_SKIP
  } lead_t;

  typedef struct packed {
    logic  clear_track;
    logic  ld_note;
    logic  ld_fx;
    logic  ld_info;
    logic  start_skip;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    lead_t lead;
    logic  info_eff_zero;
    logic  out_free;
    logic  skip_last;
  } sts_t;

  localparam logic [7:0] SKIP_MIN      = 8'hC0;
  localparam logic [7:0] FX_MIN        = 8'h80;
  localparam logic [6:0] HI_SAMPLE_MIN = 7'h5B;
  localparam logic [6:0] NOTE_FLIP     = 7'h7F;
  localparam logic [6:0] SKIP_SPAN     = 7'd64;

  localparam logic [3:0] EFF_ARP_IN    = 4'h8;
  localparam logic [3:0] EFF_ARPEGGIO  = 4'h0;
  localparam logic [3:0] EFF_SLIDE_A   = 4'h5;
  localparam logic [3:0] EFF_SLIDE_B   = 4'h6;
  localparam logic [3:0] EFF_SLIDE_C   = 4'hA;

  // Standard three-octave periods; indexes past the octaves read zero.
  function automatic logic [11:0] period_of(input logic [5:0] idx);
    logic [11:0] p;
    unique case (idx)
      6'd0:  p = 12'd856;
      6'd1:  p = 12'd808;
      6'd2:  p = 12'd762;
      6'd3:  p = 12'd720;
      6'd4:  p = 12'd678;
      6'd5:  p = 12'd640;
      6'd6:  p = 12'd604;
      6'd7:  p = 12'd570;
      6'd8:  p = 12'd538;
      6'd9:  p = 12'd508;
      6'd10: p = 12'd480;
      6'd11: p = 12'd453;
      6'd12: p = 12'd428;
      6'd13: p = 12'd404;
      6'd14: p = 12'd381;
      6'd15: p = 12'd360;
      6'd16: p = 12'd339;
      6'd17: p = 12'd320;
      6'd18: p = 12'd302;
      6'd19: p = 12'd285;
      6'd20: p = 12'd269;
      6'd21: p = 12'd254;
      6'd22: p = 12'd240;
      6'd23: p = 12'd226;
      6'd24: p = 12'd214;
      6'd25: p = 12'd202;
      6'd26: p = 12'd190;
      6'd27: p = 12'd180;
      6'd28: p = 12'd170;
      6'd29: p = 12'd160;
      6'd30: p = 12'd151;
      6'd31: p = 12'd143;
      6'd32: p = 12'd135;
      6'd33: p = 12'd127;
      6'd34: p = 12'd120;
      6'd35: p = 12'd113;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

[hdl/packed_track_cell_decoder.sv]
// Top level of the packed track cell decoder.
// Decodes the packed byte stream of one track into row cells, one word per
// row on the out channel. Lead, info, parameter and effect-only bytes are
// taken at one per cycle whenever the output register is free or being
// emptied in that cycle; a byte that finishes a cell loads that register at
// the edge that accepts it. After a skip lead byte (0xC0 and above) the block
// emits one empty row per cycle while the output register is free, 256 minus
// its value rows clamped at the end of the track; during that run the in
// channel holds ready low. Back pressure on out stalls the input side, as the
// block has a single output register. Row count restarts on a word with
// track_start set and wraps after the last row. format_mode selects the older
// (0) or newer (1, reset value) encoding. The user must see that it is written
// only while the block is idle, which is not enforced. cfg_ready is always high.
module packed_track_cell_decoder #(
  parameter int ROWS_PER_TRACK = 64,
  parameter int NOTE_COUNT     = 36
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        format_mode,
  // decoded cells
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  row_index,
  output logic [4:0]  sample_number,
  output logic [11:0] note_period,
  output logic [3:0]  effect_code,
  output logic [7:0]  effect_param,
  output logic        bad_note,
  output logic        last_row
);

  ptcd_pkg::cmd_t cmd;
  ptcd_pkg::sts_t sts;

  // Take configuration words at any time.
  assign cfg_ready = 1'b1;

  // Sequence the parse phases and skip runs.
  ptcd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .track_start (track_start),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Decode bytes, hold the pending cell and drive the output register.
  ptcd_datapath #(
    .ROWS_PER_TRACK (ROWS_PER_TRACK),
    .NOTE_COUNT     (NOTE_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .data_byte     (data_byte),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_mode      (format_mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .row_index     (row_index),
    .sample_number (sample_number),
    .note_period   (note_period),
    .effect_code   (effect_code),
    .effect_param  (effect_param),
    .bad_note      (bad_note),
    .last_row      (last_row)
  );

endmodule

[hdl/ptcd_ctrl.sv]
// Controller of the packed track cell decoder: parse phase and skip sequencing.
module ptcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              track_start,
  output logic              in_ready,
  input  ptcd_pkg::sts_t    sts,
  output ptcd_pkg::cmd_t    cmd
);

`include "packed_track_cell_decoder_macros.svh"

  ptcd_pkg::state_t state, state_next, phase;
  logic accept;

  assign in_ready = (state != ptcd_pkg::ST_SKIP) && sts.out_free;
  assign accept   = in_valid && in_ready;
  // A track start forces the parser back to the lead byte.
  assign phase    = (track_start && state != ptcd_pkg::ST_SKIP) ? ptcd_pkg::ST_LEAD : state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptcd_pkg::ST_LEAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (state == ptcd_pkg::ST_SKIP) begin
      if (sts.out_free && sts.skip_last) begin
        state_next = ptcd_pkg::ST_LEAD;
      end
    end else if (accept) begin
      unique case (phase)
        ptcd_pkg::ST_LEAD: begin
          unique case (sts.lead)
            ptcd_pkg::LEAD_SKIP: state_next = ptcd_pkg::ST_SKIP;
            ptcd_pkg::LEAD_FX:   state_next = ptcd_pkg::ST_PARAM;
            default:             state_next = ptcd_pkg::ST_INFO;
          endcase
        end
        ptcd_pkg::ST_INFO: begin
          state_next = sts.info_eff_zero ? ptcd_pkg::ST_LEAD : ptcd_pkg::ST_PARAM;
        end
        default: state_next = ptcd_pkg::ST_LEAD;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.emit        = ptcd_pkg::EMIT_NONE;
    cmd.clear_track = accept && track_start;
    if (state == ptcd_pkg::ST_SKIP) begin
      if (sts.out_free) begin
        cmd.emit = ptcd_pkg::EMIT_EMPTY;
      end
    end else if (accept) begin
      unique case (phase)
        ptcd_pkg::ST_LEAD: begin
          unique case (sts.lead)
            ptcd_pkg::LEAD_SKIP: cmd.start_skip = 1'b1;
            ptcd_pkg::LEAD_FX:   cmd.ld_fx      = 1'b1;
            default:             cmd.ld_note    = 1'b1;
          endcase
        end
        ptcd_pkg::ST_INFO: begin
          cmd.ld_info = 1'b1;
          if (sts.info_eff_zero) begin
            cmd.emit = ptcd_pkg::EMIT_INFO;
          end
        end
        default: cmd.emit = ptcd_pkg::EMIT_PARAM;
      endcase
    end
  end

  `PTCD_ASSERT_SAME(a_emit_free, cmd.emit != ptcd_pkg::EMIT_NONE, sts.out_free, "cell emitted into a full output register")

endmodule

[hdl/ptcd_datapath.sv]
// Datapath of the packed track cell decoder: byte decode, pending cell, row count, output.
module ptcd_datapath #(
  parameter int ROWS_PER_TRACK = 64,
  parameter int NOTE_COUNT     = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  ptcd_pkg::cmd_t    cmd,
  output ptcd_pkg::sts_t    sts,
  input  logic [7:0]        data_byte,
  input  logic              cfg_we,
  input  logic              cfg_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        row_index,
  output logic [4:0]        sample_number,
  output logic [11:0]       note_period,
  output logic [3:0]        effect_code,
  output logic [7:0]        effect_param,
  output logic              bad_note,
  output logic              last_row
);

`include "packed_track_cell_decoder_macros.svh"

  localparam int RowW = $clog2(ROWS_PER_TRACK + 1);

  logic            fmt_mode;
  logic [RowW-1:0] row_counter;
  logic [6:0]      skip_count;
  logic [11:0]     pend_period;
  logic            pend_hi;
  logic [3:0]      pend_lo;
  logic [3:0]      pend_eff;
  logic            pend_bad;

  logic [RowW-1:0] row_eff;
  logic            out_free;

  // Note decode of a lead byte.
  logic [6:0]  note_v;
  logic [6:0]  note_idx;
  logic        note_has;
  logic        note_hi;
  logic        note_bad;
  logic [11:0] note_per;
  logic [3:0]  fx_eff;

  // Parameter conversion.
  logic [3:0]  conv_eff;
  logic [7:0]  conv_param;

  assign out_free = !out_valid || out_ready;
  assign row_eff  = (row_counter >= RowW'(ROWS_PER_TRACK)) ? '0 : row_counter;

  always_comb begin
    if (fmt_mode == 1'b0) begin
      note_hi = data_byte[0];
      note_v  = {1'b0, data_byte[6:1]};
    end else if (data_byte[6:0] >= ptcd_pkg::HI_SAMPLE_MIN) begin
      note_hi = 1'b1;
      note_v  = ptcd_pkg::NOTE_FLIP - data_byte[6:0];
    end else begin
      note_hi = 1'b0;
      note_v  = data_byte[6:0];
    end
    note_has = note_v != 7'd0;
    note_idx = note_v - 7'd1;
    note_bad = note_has && (note_idx >= 7'(NOTE_COUNT));
    note_per = (note_has && !note_bad) ? ptcd_pkg::period_of(note_idx[5:0]) : 12'd0;
  end

  assign fx_eff = fmt_mode ? data_byte[4:1] : data_byte[5:2];

  always_comb begin
    conv_eff   = (pend_eff == ptcd_pkg::EFF_ARP_IN) ? ptcd_pkg::EFF_ARPEGGIO : pend_eff;
    conv_param = data_byte;
    if (pend_eff == ptcd_pkg::EFF_SLIDE_A || pend_eff == ptcd_pkg::EFF_SLIDE_B ||
        pend_eff == ptcd_pkg::EFF_SLIDE_C) begin
      conv_param = data_byte[7] ? (~data_byte + 8'd1) : {data_byte[3:0], 4'h0};
    end
  end

  always_comb begin
    if (data_byte >= ptcd_pkg::SKIP_MIN) begin
      sts.lead = ptcd_pkg::LEAD_SKIP;
    end else if (data_byte >= ptcd_pkg::FX_MIN) begin
      sts.lead = ptcd_pkg::LEAD_FX;
    end else begin
      sts.lead = ptcd_pkg::LEAD_NOTE;
    end
    sts.info_eff_zero = data_byte[3:0] == 4'h0;
    sts.out_free      = out_free;
    sts.skip_last     = (skip_count == 7'd1) || (row_eff == RowW'(ROWS_PER_TRACK - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_mode <= 1'b1;
    end else if (cfg_we) begin
      fmt_mode <= cfg_mode;
    end
  end

  // Row counter: clear on track start, wrap once a full track has gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
    end else if (cmd.emit != ptcd_pkg::EMIT_NONE) begin
      row_counter <= row_eff + RowW'(1);
    end else if (cmd.start_skip) begin
      row_counter <= cmd.clear_track ? '0 : row_eff;
    end else if (cmd.clear_track) begin
      row_counter <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_skip) begin
      skip_count <= ptcd_pkg::SKIP_SPAN - {1'b0, data_byte[5:0]};
    end else if (cmd.emit == ptcd_pkg::EMIT_EMPTY) begin
      skip_count <= skip_count - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_note) begin
      pend_period <= note_per;
      pend_hi     <= note_hi;
      pend_lo     <= 4'h0;
      pend_eff    <= 4'h0;
      pend_bad    <= note_bad;
    end else if (cmd.ld_fx) begin
      pend_period <= 12'd0;
      pend_hi     <= 1'b0;
      pend_lo     <= 4'h0;
      pend_eff    <= fx_eff;
      pend_bad    <= 1'b0;
    end else if (cmd.ld_info) begin
      pend_lo  <= data_byte[7:4];
      pend_eff <= data_byte[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != ptcd_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != ptcd_pkg::EMIT_NONE) begin
      row_index <= 6'(row_eff);
      last_row  <= row_eff == RowW'(ROWS_PER_TRACK - 1);
      unique case (cmd.emit)
        ptcd_pkg::EMIT_INFO: begin
          sample_number <= {pend_hi, data_byte[7:4]};
          note_period   <= pend_period;
          effect_code   <= 4'h0;
          effect_param  <= 8'h00;
          bad_note      <= pend_bad;
        end
        ptcd_pkg::EMIT_PARAM: begin
          sample_number <= {pend_hi, pend_lo};
          note_period   <= pend_period;
          effect_code   <= conv_eff;
          effect_param  <= conv_param;
          bad_note      <= pend_bad;
        end
        default: begin
          sample_number <= 5'd0;
          note_period   <= 12'd0;
          effect_code   <= 4'h0;
          effect_param  <= 8'h00;
          bad_note      <= 1'b0;
        end
      endcase
    end
  end

  `PTCD_ASSERT_SAME(a_row_range, 1'b1, row_counter <= RowW'(ROWS_PER_TRACK), "row counter beyond track length")
  `PTCD_ASSERT_SAME(a_last_row, out_valid && last_row, row_index == 6'(ROWS_PER_TRACK - 1), "last row flag on wrong row")
  `PTCD_ASSERT_NEXT(a_empty_cell, cmd.emit == ptcd_pkg::EMIT_EMPTY, out_valid && note_period == 12'd0 && sample_number == 5'd0, "skipped row is not empty")

endmodule
